// File: sv/udbg_pkg.sv
// Package with the shared types, register offsets and bit codes of the debug UART register block.
`timescale 1ns / 1ps

package udbg_pkg;

  // Item modes
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_RX    = 2'd2;

  // Register offsets (byte offsets within the block)
  localparam logic [8:0] OFF_CTRL     = 9'h000;
  localparam logic [8:0] OFF_MODE     = 9'h004;
  localparam logic [8:0] OFF_MASK_EN  = 9'h008;
  localparam logic [8:0] OFF_MASK_DIS = 9'h00c;
  localparam logic [8:0] OFF_MASK     = 9'h010;
  localparam logic [8:0] OFF_STATUS   = 9'h014;
  localparam logic [8:0] OFF_RHR      = 9'h018;
  localparam logic [8:0] OFF_THR      = 9'h01c;
  localparam logic [8:0] OFF_BAUD     = 9'h020;
  localparam logic [8:0] OFF_CHIP_ID  = 9'h040;
  localparam logic [8:0] OFF_CHIP_EXT = 9'h044;
  localparam logic [8:0] OFF_FORCE    = 9'h048;

  // Configuration register indexes
  localparam logic [7:0] CFG_CHIP_ID  = 8'd0;
  localparam logic [7:0] CFG_CHIP_EXT = 8'd1;

  // Status bits
  localparam logic [31:0] ST_RX_READY    = 32'h0000_0001;
  localparam logic [31:0] ST_TX_READY    = 32'h0000_0002;
  localparam logic [31:0] ST_ERRORS      = 32'h0000_00e0;
  localparam logic [31:0] ST_TX_EMPTY    = 32'h0000_0200;
  localparam logic [31:0] ST_TXBUF_EMPTY = 32'h0000_0800;
  localparam logic [31:0] ST_RESET       = ST_TX_READY | ST_TX_EMPTY | ST_TXBUF_EMPTY;

  // Control bit positions
  localparam int unsigned CT_RX_ON_BIT  = 4;
  localparam int unsigned CT_RX_OFF_BIT = 5;
  localparam int unsigned CT_TX_ON_BIT  = 6;
  localparam int unsigned CT_TX_OFF_BIT = 7;
  localparam int unsigned CT_CLR_BIT    = 8;

  localparam logic [31:0] CHIP_ID_RESET = 32'h275b_0940;

  typedef struct packed {
    logic [1:0]  mode;
    logic [8:0]  reg_offset;
    logic [31:0] write_data;
    logic [7:0]  line_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
    logic        tx_valid;
    logic [7:0]  tx_char;
    logic        can_accept;
    logic        rx_dropped;
  } result_t;

endpackage

// File: sv/udbg_core.sv
// Register state of the debug UART and the single-pass update and result logic.
`timescale 1ns / 1ps

module udbg_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  udbg_pkg::item_t    item_i,
  input  logic [31:0]        chip_id_i,
  input  logic [31:0]        chip_ext_i,
  output udbg_pkg::result_t  result_o
);

  logic        rx_en_q, rx_en_d;
  logic        tx_en_q, tx_en_d;
  logic [31:0] mode_word_q, mode_word_d;
  logic [31:0] mask_q, mask_d;
  logic [31:0] status_q, status_d;
  logic [7:0]  rhr_q, rhr_d;
  logic [7:0]  thr_q, thr_d;
  logic [15:0] baud_q, baud_d;
  logic [31:0] force_q, force_d;

  logic [31:0] rd;
  logic        txv;
  logic [7:0]  txc;
  logic        dropped;

  always_comb begin
    rx_en_d     = rx_en_q;
    tx_en_d     = tx_en_q;
    mode_word_d = mode_word_q;
    mask_d      = mask_q;
    status_d    = status_q;
    rhr_d       = rhr_q;
    thr_d       = thr_q;
    baud_d      = baud_q;
    force_d     = force_q;
    rd          = '0;
    txv         = 1'b0;
    txc         = '0;
    dropped     = 1'b0;

    unique case (item_i.mode)
      udbg_pkg::MODE_READ: begin
        unique case (item_i.reg_offset)
          udbg_pkg::OFF_MODE:     rd = mode_word_q;
          udbg_pkg::OFF_MASK:     rd = mask_q;
          udbg_pkg::OFF_STATUS:   rd = status_q;
          udbg_pkg::OFF_RHR: begin
            rd       = {24'd0, rhr_q};
            status_d = status_q & ~udbg_pkg::ST_RX_READY;
          end
          udbg_pkg::OFF_BAUD:     rd = {16'd0, baud_q};
          udbg_pkg::OFF_CHIP_ID:  rd = chip_id_i;
          udbg_pkg::OFF_CHIP_EXT: rd = chip_ext_i;
          udbg_pkg::OFF_FORCE:    rd = force_q;
          default:                rd = '0;
        endcase
      end
      udbg_pkg::MODE_WRITE: begin
        unique case (item_i.reg_offset)
          udbg_pkg::OFF_CTRL: begin
            // disable wins over enable
            if (item_i.write_data[udbg_pkg::CT_RX_OFF_BIT]) begin
              rx_en_d = 1'b0;
            end else if (item_i.write_data[udbg_pkg::CT_RX_ON_BIT]) begin
              rx_en_d = 1'b1;
            end
            if (item_i.write_data[udbg_pkg::CT_TX_OFF_BIT]) begin
              tx_en_d = 1'b0;
            end else if (item_i.write_data[udbg_pkg::CT_TX_ON_BIT]) begin
              tx_en_d = 1'b1;
            end
            if (item_i.write_data[udbg_pkg::CT_CLR_BIT]) begin
              status_d = status_q & ~udbg_pkg::ST_ERRORS;
            end
          end
          udbg_pkg::OFF_MODE:     mode_word_d = item_i.write_data;
          udbg_pkg::OFF_MASK_EN:  mask_d = mask_q | item_i.write_data;
          udbg_pkg::OFF_MASK_DIS: mask_d = mask_q & ~item_i.write_data;
          udbg_pkg::OFF_THR: begin
            if (tx_en_q) begin
              thr_d    = item_i.write_data[7:0];
              txv      = 1'b1;
              txc      = item_i.write_data[7:0];
              status_d = status_q | udbg_pkg::ST_TX_READY | udbg_pkg::ST_TXBUF_EMPTY
                         | udbg_pkg::ST_TX_EMPTY;
            end
          end
          udbg_pkg::OFF_BAUD:     baud_d = item_i.write_data[15:0];
          udbg_pkg::OFF_FORCE:    force_d = item_i.write_data;
          default:                ;
        endcase
      end
      udbg_pkg::MODE_RX: begin
        if (rx_en_q && !status_q[0]) begin
          rhr_d    = item_i.line_byte;
          status_d = status_q | udbg_pkg::ST_RX_READY;
        end else begin
          dropped = 1'b1;
        end
      end
      default: ;
    endcase

    result_o.read_data  = rd;
    result_o.irq_level  = |(status_d & mask_d);
    result_o.tx_valid   = txv;
    result_o.tx_char    = txc;
    result_o.can_accept = rx_en_d & ~status_d[0];
    result_o.rx_dropped = dropped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_en_q     <= 1'b0;
      tx_en_q     <= 1'b0;
      mode_word_q <= '0;
      mask_q      <= '0;
      status_q    <= udbg_pkg::ST_RESET;
      rhr_q       <= '0;
      thr_q       <= '0;
      baud_q      <= '0;
      force_q     <= '0;
    end else if (advance_i) begin
      rx_en_q     <= rx_en_d;
      tx_en_q     <= tx_en_d;
      mode_word_q <= mode_word_d;
      mask_q      <= mask_d;
      status_q    <= status_d;
      rhr_q       <= rhr_d;
      thr_q       <= thr_d;
      baud_q      <= baud_d;
      force_q     <= force_d;
    end
  end

endmodule

// File: sv/uart_debug_unit_registers.sv
// Top level of the debug UART register block: input register, result register, id registers.
`timescale 1ns / 1ps

// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_ready_o | mode_i, reg_offset_i, write_data_i, line_byte_i
// out     | output    | out_valid_o/out_ready_i | read_data_o, irq_level_o, tx_valid_o,
//         |           |                       | tx_char_o, can_accept_o, rx_dropped_o
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One beat per cycle sustained while the output is not stalled; a beat passes through the
// input register, then the result register, before its result is offered.
// The register update and the result are one pass of logic in the core between
// those two registers.
// Reset is asynchronous, active low; it empties both stages and loads the
// register reset values (status 0xa02, chip id 0x275b0940).
// A stalled output holds its result while the input register may still fill;
// input ready drops only when both stages hold beats and the output stalls.

module uart_debug_unit_registers (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [8:0]  reg_offset_i,
  input  logic [31:0] write_data_i,
  input  logic [7:0]  line_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic        irq_level_o,
  output logic        tx_valid_o,
  output logic [7:0]  tx_char_o,
  output logic        can_accept_o,
  output logic        rx_dropped_o,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic              in_vld_q;
  udbg_pkg::item_t   item_q;
  logic              out_vld_q;
  udbg_pkg::result_t res_q;
  udbg_pkg::result_t res_d;
  logic [31:0]       chip_id_q;
  logic [31:0]       chip_ext_q;
  logic              advance;
  logic              in_take;

  // Move the held beat into the result register when that slot is free or draining.
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  // Payload register: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.mode       <= mode_i;
      item_q.reg_offset <= reg_offset_i;
      item_q.write_data <= write_data_i;
      item_q.line_byte  <= line_byte_i;
    end
  end

  udbg_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .item_i     (item_q),
    .chip_id_i  (chip_id_q),
    .chip_ext_i (chip_ext_q),
    .result_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Identification registers; writes to indexes past the list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_id_q  <= udbg_pkg::CHIP_ID_RESET;
      chip_ext_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == udbg_pkg::CFG_CHIP_ID) begin
        chip_id_q <= cfg_data_i;
      end
      if (cfg_index_i == udbg_pkg::CFG_CHIP_EXT) begin
        chip_ext_q <= cfg_data_i;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign read_data_o  = res_q.read_data;
  assign irq_level_o  = res_q.irq_level;
  assign tx_valid_o   = res_q.tx_valid;
  assign tx_char_o    = res_q.tx_char;
  assign can_accept_o = res_q.can_accept;
  assign rx_dropped_o = res_q.rx_dropped;

endmodule
